// ===== design/bcp_pkg.sv =====
`default_nettype none

package bcp_pkg;

  localparam int N_W    = 6;
  localparam int COEF_W = 32;

  typedef logic [N_W-1:0]    idx_t;
  typedef logic [COEF_W-1:0] coef_t;

  localparam coef_t COEF_SAT = '1;
  localparam coef_t COEF_ONE = coef_t'(1);

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_DRAIN,
    ENG_HOLD
  } eng_state_t;

  typedef struct packed {
    idx_t n;
    idx_t k;
  } job_t;

  typedef struct packed {
    coef_t coefficient;
    logic  invalid;
    logic  overflow;
  } res_t;

endpackage

`default_nettype wire

// ===== design/bcp_if.sv =====
`default_nettype none

interface bcp_in_if;
  logic              valid;
  logic              ready;
  bcp_pkg::idx_t     n;
  bcp_pkg::idx_t     k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

interface bcp_out_if;
  logic              valid;
  logic              ready;
  bcp_pkg::coef_t    coefficient;
  logic              invalid;
  logic              overflow;

  modport source (output valid, output coefficient, output invalid, output overflow,
                  input ready);
  modport sink   (input valid, input coefficient, input invalid, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== design/bcp_row_mem.sv =====
`default_nettype none

module bcp_row_mem #(
  parameter int AW = 5
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire bcp_pkg::coef_t      wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output bcp_pkg::coef_t           rdata
);
  import bcp_pkg::*;

  localparam int DEPTH = 1 << AW;

  coef_t mem [DEPTH];
  coef_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a read of the entry being written returns the new value
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/bcp_engine.sv =====
`default_nettype none

module bcp_engine #(
  parameter int MAX_N = 63,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire bcp_pkg::job_t job,
  output logic               idle,
  output logic               res_valid,
  output bcp_pkg::res_t      res,
  input  wire logic          res_take
);
  import bcp_pkg::*;

  localparam idx_t MAX_N_V = N_W'(MAX_N);

  eng_state_t state_r, state_nxt;

  idx_t          n_r;
  idx_t          row_r;
  idx_t          p_row_r;
  logic [AW-1:0] kk_r;
  logic [AW-1:0] col_r;
  logic [AW-1:0] p_col_r;
  logic          p_valid_r;
  logic          p_last_r;
  coef_t         hold_r;
  logic          ovf_r;
  res_t          res_r;

  idx_t          n_minus_k;
  idx_t          kk_full;
  logic          sp_invalid;
  logic          sp_one;
  logic          special;
  logic          last_issue;

  logic          mem_re;
  logic          mem_we;
  coef_t         mem_rdata;
  coef_t         old_val;
  logic [COEF_W:0] sum;
  logic          carry;
  coef_t         sat;

  // decode of the incoming item
  always_comb begin
    n_minus_k  = job.n - job.k;
    sp_invalid = (job.n > MAX_N_V) || (job.k > job.n);
    sp_one     = (job.k == '0) || (job.k == job.n);
    special    = sp_invalid || sp_one;
    kk_full    = (job.k <= n_minus_k) ? job.k : n_minus_k;
  end

  assign last_issue = (col_r == kk_r) && (row_r == n_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ENG_IDLE: begin
        if (start) begin
          state_nxt = special ? ENG_HOLD : ENG_RUN;
        end
      end
      ENG_RUN: begin
        if (last_issue) begin
          state_nxt = ENG_DRAIN;
        end
      end
      ENG_DRAIN: state_nxt = ENG_HOLD;
      ENG_HOLD: begin
        if (res_take) begin
          state_nxt = ENG_IDLE;
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    res_valid = 1'b0;
    mem_re    = 1'b0;
    case (state_r)
      ENG_IDLE: idle      = 1'b1;
      ENG_RUN:  mem_re    = 1'b1;
      ENG_HOLD: res_valid = 1'b1;
      default: ;
    endcase
  end

  // entries right of the diagonal of the previous row read as zero
  always_comb begin
    old_val = ({{(N_W-AW){1'b0}}, p_col_r} >= p_row_r) ? '0 : mem_rdata;
    sum     = {1'b0, old_val} + {1'b0, hold_r};
    carry   = sum[COEF_W];
    sat     = carry ? COEF_SAT : sum[COEF_W-1:0];
    mem_we  = p_valid_r;
  end

  bcp_row_mem #(.AW(AW)) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (p_col_r),
    .wdata (sat),
    .re    (mem_re),
    .raddr (col_r),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ENG_IDLE;
      p_valid_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= mem_re;
      if (state_r == ENG_IDLE && start) begin
        ovf_r <= 1'b0;
      end else if (p_valid_r) begin
        ovf_r <= ovf_r | carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_col_r  <= col_r;
    p_row_r  <= row_r;
    p_last_r <= last_issue;
    if (state_r == ENG_IDLE && start) begin
      n_r    <= job.n;
      kk_r   <= kk_full[AW-1:0];
      row_r  <= idx_t'(1);
      col_r  <= AW'(1);
      hold_r <= COEF_ONE;
      if (sp_invalid) begin
        res_r <= '{coefficient: '0, invalid: 1'b1, overflow: 1'b0};
      end else begin
        res_r <= '{coefficient: COEF_ONE, invalid: 1'b0, overflow: 1'b0};
      end
    end else begin
      if (state_r == ENG_RUN) begin
        // sweep the columns of one row, then advance to the next row
        if (col_r == kk_r) begin
          col_r <= AW'(1);
          row_r <= row_r + idx_t'(1);
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
      if (p_valid_r) begin
        // hold the old left neighbour; column zero is always one
        hold_r <= (p_col_r == kk_r) ? COEF_ONE : old_val;
        if (p_last_r) begin
          res_r <= '{coefficient: sat, invalid: 1'b0, overflow: ovf_r | carry};
        end
      end
    end
  end

  assign res = res_r;

  a_wr_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (p_col_r != '0) && (p_col_r <= kk_r))
    else $error("row store written outside columns 1..kk");

  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_HOLD) |-> !p_valid_r)
    else $error("row store still busy while result is held");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_HOLD && res_r.overflow) |-> (res_r.coefficient == COEF_SAT))
    else $error("overflow flagged without saturated coefficient");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_HOLD && res_r.invalid) |-> (res_r.coefficient == '0) && !res_r.overflow)
    else $error("invalid item gave nonzero result");

  a_run_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_IDLE && start && !special) |=> (state_r == ENG_RUN) && (row_r == idx_t'(1)))
    else $error("computation did not start on row one");

endmodule

`default_nettype wire

// ===== design/binomial_coefficient_pascal.sv =====
`default_nettype none

// Binomial coefficient C(n,k) by Pascal's triangle. Each item (n, k) gives one
// result. Only columns 1..kk of the triangle are built, kk = min(k, n-k), in a
// row memory of MAX_N/2+1 entries (rounded up to a power of two) that one
// saturating 32-bit adder updates in place: while the rows are swept, every
// cycle reads one entry, and the sum for the entry read in the previous cycle
// is written back, with write-first forwarding on the memory. An item with
// k > n (or n > MAX_N) returns 0 with invalid set; k = 0 or k = n returns 1;
// either goes from accept straight to HOLD. Any other item sweeps rows 1..n,
// columns 1..kk, in RUN, then passes DRAIN and HOLD. A result that passes 32
// bits reads all ones with overflow set. The row memory needs no clearing after
// reset. A new item is accepted while the previous result waits at the output.
module binomial_coefficient_pascal #(
  parameter int MAX_N = 63
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bcp_in_if.sink    in_ch,
  bcp_out_if.source out_ch
);
  import bcp_pkg::*;

  localparam int ROW_DEPTH = MAX_N / 2 + 1;
  localparam int AW        = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

  logic  eng_idle;
  logic  eng_start;
  job_t  eng_job;
  logic  res_valid;
  res_t  eng_res;
  logic  res_take;
  logic  slot_free;

  logic  out_valid_r;
  res_t  out_res_r;

  assign in_ch.ready = eng_idle;
  assign eng_start   = in_ch.valid && eng_idle;
  assign eng_job     = '{n: in_ch.n, k: in_ch.k};

  bcp_engine #(.MAX_N(MAX_N), .AW(AW)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (eng_start),
    .job       (eng_job),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res       (eng_res),
    .res_take  (res_take)
  );

  // output register: load when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ch.ready;
  assign res_take  = res_valid && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= eng_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.coefficient = out_res_r.coefficient;
  assign out_ch.invalid     = out_res_r.invalid;
  assign out_ch.overflow    = out_res_r.overflow;

endmodule

`default_nettype wire
